>>> rtl/psm_pkg.sv
package psm_pkg;

  localparam int MAX_MODEL_POINTS = 64;
  localparam int IDX_W = (MAX_MODEL_POINTS > 1) ? $clog2(MAX_MODEL_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_MODEL_POINTS + 1);
  localparam int COORD_W = 16;
  localparam int RADIUS_W = 16;
  localparam int RADIUS_SQ_W = 2 * RADIUS_W;
  localparam int DIST_SQ_W = 2 * COORD_W + 2;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] OP_CLASSIFY = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] CLASS_ROBOT = 2'd0;
  localparam logic [1:0] CLASS_INTEREST = 2'd1;
  localparam logic [1:0] CLASS_ELSEWHERE = 2'd2;

  localparam logic [0:0] REG_ROBOT_RADIUS = 1'b0;
  localparam logic [0:0] REG_INTEREST_RADIUS = 1'b1;

  localparam logic [RADIUS_W-1:0] ROBOT_RADIUS_RST = 16'd100;
  localparam logic [RADIUS_W-1:0] INTEREST_RADIUS_RST = 16'd500;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } cmd_t;

  typedef struct packed {
    logic [1:0] point_class;
    logic keep_point;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
  } res_t;

  typedef struct packed {
    logic start;
    logic valid;
  } feed_ctl_t;

  typedef struct packed {
    logic robot;
    logic near;
  } flags_t;

endpackage

>>> rtl/psm_cell.sv
module psm_cell (
  input  logic            clk,
  input  logic            shift,
  input  psm_pkg::point_t prev,
  output psm_pkg::point_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= prev;
    end
  end

endmodule

>>> rtl/psm_dist.sv
module psm_dist (
  input  logic                             clk,
  input  logic                             rst,
  input  psm_pkg::feed_ctl_t               ctl,
  input  psm_pkg::point_t                  entry,
  input  psm_pkg::point_t                  query,
  input  logic [psm_pkg::RADIUS_W-1:0]     robot_radius,
  input  logic [psm_pkg::RADIUS_W-1:0]     interest_radius,
  output psm_pkg::flags_t                  flags
);

  logic [psm_pkg::RADIUS_SQ_W-1:0] rsq;
  logic [psm_pkg::RADIUS_SQ_W-1:0] isq;
  logic signed [psm_pkg::COORD_W:0] dx, dy, dz;
  logic [psm_pkg::COORD_W-1:0] adx, ady, adz;
  logic [psm_pkg::COORD_W-1:0] adx_r, ady_r, adz_r;
  logic va;
  logic [2*psm_pkg::COORD_W-1:0] sx, sy, sz;
  logic vb;
  logic [psm_pkg::DIST_SQ_W-1:0] dsum;

  always_comb begin
    dx = $signed({query.x[psm_pkg::COORD_W-1], query.x})
       - $signed({entry.x[psm_pkg::COORD_W-1], entry.x});
    dy = $signed({query.y[psm_pkg::COORD_W-1], query.y})
       - $signed({entry.y[psm_pkg::COORD_W-1], entry.y});
    dz = $signed({query.z[psm_pkg::COORD_W-1], query.z})
       - $signed({entry.z[psm_pkg::COORD_W-1], entry.z});
    adx = dx[psm_pkg::COORD_W] ? psm_pkg::COORD_W'(-dx) : dx[psm_pkg::COORD_W-1:0];
    ady = dy[psm_pkg::COORD_W] ? psm_pkg::COORD_W'(-dy) : dy[psm_pkg::COORD_W-1:0];
    adz = dz[psm_pkg::COORD_W] ? psm_pkg::COORD_W'(-dz) : dz[psm_pkg::COORD_W-1:0];
  end

  assign dsum = psm_pkg::DIST_SQ_W'(sx) + psm_pkg::DIST_SQ_W'(sy)
              + psm_pkg::DIST_SQ_W'(sz);

  always_ff @(posedge clk) begin
    rsq <= psm_pkg::RADIUS_SQ_W'(robot_radius) * psm_pkg::RADIUS_SQ_W'(robot_radius);
    isq <= psm_pkg::RADIUS_SQ_W'(interest_radius)
         * psm_pkg::RADIUS_SQ_W'(interest_radius);
    adx_r <= adx;
    ady_r <= ady;
    adz_r <= adz;
    sx <= (2*psm_pkg::COORD_W)'(adx_r) * (2*psm_pkg::COORD_W)'(adx_r);
    sy <= (2*psm_pkg::COORD_W)'(ady_r) * (2*psm_pkg::COORD_W)'(ady_r);
    sz <= (2*psm_pkg::COORD_W)'(adz_r) * (2*psm_pkg::COORD_W)'(adz_r);
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      flags <= '0;
    end else begin
      va <= ctl.valid;
      vb <= va;
      if (ctl.start) begin
        flags <= '0;
      end else if (vb) begin
        if (dsum < psm_pkg::DIST_SQ_W'(rsq)) begin
          flags.robot <= 1'b1;
        end
        if (dsum < psm_pkg::DIST_SQ_W'(isq)) begin
          flags.near <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/point_sphere_model_classifier_core.sv
// A classify rotates the cell chain once past the single distance unit, whatever
// the table fill, then passes the drain state; its result is registered in the
// done state, which holds while a pending result is stalled. No new command is
// taken until a classify ends; append and clear never leave the idle state.
// Reset (synchronous, rst high): table empty, radii 100 mm and 500 mm, no
// result pending; table contents are not cleared.
module point_sphere_model_classifier_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  psm_pkg::cmd_t                      cmd,
  output logic                               res_valid,
  input  logic                               res_stall,
  output psm_pkg::res_t                      res,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [psm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [psm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [psm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_DONE} state_t;

  state_t state;
  logic [psm_pkg::CNT_W-1:0] count;
  logic [psm_pkg::IDX_W-1:0] step;
  logic drain;
  psm_pkg::point_t query;
  logic [psm_pkg::RADIUS_W-1:0] robot_radius;
  logic [psm_pkg::RADIUS_W-1:0] interest_radius;
  psm_pkg::point_t chain [psm_pkg::MAX_MODEL_POINTS];
  psm_pkg::point_t head_in;
  psm_pkg::point_t cmd_point;
  logic cmd_fire;
  logic append_fire;
  logic shift;
  logic [psm_pkg::CNT_W:0] reach;
  psm_pkg::feed_ctl_t feed;
  psm_pkg::flags_t flags;
  logic [0:0] reg_idx;
  logic [1:0] cls;

  assign pready = 1'b1;
  assign reg_idx = paddr[2:2];
  assign cmd_stall = (state != ST_IDLE);
  assign cmd_fire = cmd_valid && !cmd_stall;
  assign cmd_point = '{x: cmd.pos_x, y: cmd.pos_y, z: cmd.pos_z};
  assign append_fire = cmd_fire && (cmd.opcode == psm_pkg::OP_APPEND)
                    && (count < psm_pkg::CNT_W'(psm_pkg::MAX_MODEL_POINTS));
  assign shift = append_fire || (state == ST_WALK);
  assign head_in = append_fire ? cmd_point : chain[psm_pkg::MAX_MODEL_POINTS-1];
  assign reach = (psm_pkg::CNT_W+1)'(step) + (psm_pkg::CNT_W+1)'(count);
  assign feed.start = cmd_fire && (cmd.opcode == psm_pkg::OP_CLASSIFY);
  assign feed.valid = (state == ST_WALK)
                   && (reach >= (psm_pkg::CNT_W+1)'(psm_pkg::MAX_MODEL_POINTS));

  always_comb begin
    if (flags.robot) begin
      cls = psm_pkg::CLASS_ROBOT;
    end else if (flags.near) begin
      cls = psm_pkg::CLASS_INTEREST;
    end else begin
      cls = psm_pkg::CLASS_ELSEWHERE;
    end
  end

  always_comb begin
    case (reg_idx)
      psm_pkg::REG_ROBOT_RADIUS: prdata = psm_pkg::APB_DATA_W'(robot_radius);
      psm_pkg::REG_INTEREST_RADIUS: prdata = psm_pkg::APB_DATA_W'(interest_radius);
      default: prdata = '0;
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < psm_pkg::MAX_MODEL_POINTS; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        psm_cell u_cell (.clk(clk), .shift(shift), .prev(head_in), .q(chain[gi]));
      end else begin : g_body
        psm_cell u_cell (.clk(clk), .shift(shift), .prev(chain[gi-1]), .q(chain[gi]));
      end
    end
  endgenerate

  psm_dist u_dist (
    .clk             (clk),
    .rst             (rst),
    .ctl             (feed),
    .entry           (chain[psm_pkg::MAX_MODEL_POINTS-1]),
    .query           (query),
    .robot_radius    (robot_radius),
    .interest_radius (interest_radius),
    .flags           (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      step <= '0;
      drain <= 1'b0;
      res_valid <= 1'b0;
      robot_radius <= psm_pkg::ROBOT_RADIUS_RST;
      interest_radius <= psm_pkg::INTEREST_RADIUS_RST;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx)
          psm_pkg::REG_ROBOT_RADIUS: robot_radius <= pwdata[psm_pkg::RADIUS_W-1:0];
          psm_pkg::REG_INTEREST_RADIUS:
            interest_radius <= pwdata[psm_pkg::RADIUS_W-1:0];
          default: ;
        endcase
      end
      if (res_valid && !res_stall && (state != ST_DONE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            case (cmd.opcode)
              psm_pkg::OP_CLASSIFY: begin
                query <= cmd_point;
                step <= '0;
                state <= ST_WALK;
              end
              psm_pkg::OP_APPEND: begin
                if (append_fire) begin
                  count <= count + 1'b1;
                end
              end
              psm_pkg::OP_CLEAR: count <= '0;
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          step <= step + 1'b1;
          if (step == psm_pkg::IDX_W'(psm_pkg::MAX_MODEL_POINTS - 1)) begin
            drain <= 1'b0;
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain <= 1'b1;
          if (drain) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!res_valid || !res_stall) begin
            res.point_class <= cls;
            res.keep_point <= (cls == psm_pkg::CLASS_INTEREST);
            res.out_x <= query.x;
            res.out_y <= query.y;
            res.out_z <= query.z;
            res_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= psm_pkg::CNT_W'(psm_pkg::MAX_MODEL_POINTS))
    else $error("model count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && (cmd.opcode == psm_pkg::OP_CLEAR) |=> (count == '0))
    else $error("clear did not empty the table");

  a_keep_matches_class: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.keep_point == (res.point_class == psm_pkg::CLASS_INTEREST)))
    else $error("keep flag disagrees with class");

  a_no_feed_when_idle: assert property (@(posedge clk) disable iff (rst)
    feed.valid |-> (state == ST_WALK) && cmd_stall)
    else $error("distance unit fed outside a walk");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int COORD_MAX = 32767;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_PCT = 33;
  localparam int HOLD_CYCLES = 1500;
  localparam int SETTLE_CYCLES = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  psm_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  psm_pkg::res_t res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [psm_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [psm_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [psm_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  psm_pkg::cmd_t cmd_backlog[$];
  psm_pkg::res_t results_due[$];
  int errors = 0;

  logic quiet = 1'b0;
  logic hold_arm = 1'b0;
  int hold_count = 0;

  psm_pkg::point_t model_tab[psm_pkg::MAX_MODEL_POINTS];
  int model_fill = 0;
  logic [psm_pkg::RADIUS_W-1:0] robot_r = psm_pkg::ROBOT_RADIUS_RST;
  logic [psm_pkg::RADIUS_W-1:0] interest_r = psm_pkg::INTEREST_RADIUS_RST;

  point_sphere_model_classifier_core dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void predict_command(psm_pkg::cmd_t c);
    psm_pkg::res_t r;
    longint rsq;
    longint isq;
    longint dx;
    longint dy;
    longint dz;
    longint d;
    bit hit_robot;
    bit hit_near;
    hit_robot = 1'b0;
    hit_near = 1'b0;
    case (c.opcode)
      psm_pkg::OP_CLEAR: model_fill = 0;
      psm_pkg::OP_APPEND: begin
        if (model_fill < psm_pkg::MAX_MODEL_POINTS) begin
          model_tab[model_fill].x = c.pos_x;
          model_tab[model_fill].y = c.pos_y;
          model_tab[model_fill].z = c.pos_z;
          model_fill++;
        end
      end
      psm_pkg::OP_CLASSIFY: begin
        rsq = longint'(robot_r) * longint'(robot_r);
        isq = longint'(interest_r) * longint'(interest_r);
        for (int i = 0; i < model_fill; i++) begin
          dx = longint'(c.pos_x) - longint'(model_tab[i].x);
          dy = longint'(c.pos_y) - longint'(model_tab[i].y);
          dz = longint'(c.pos_z) - longint'(model_tab[i].z);
          d = dx * dx + dy * dy + dz * dz;
          if (d < rsq) begin
            hit_robot = 1'b1;
            break;
          end
          if (d < isq) hit_near = 1'b1;
        end
        r.point_class = hit_robot ? psm_pkg::CLASS_ROBOT
                      : (hit_near ? psm_pkg::CLASS_INTEREST : psm_pkg::CLASS_ELSEWHERE);
        r.keep_point = (r.point_class == psm_pkg::CLASS_INTEREST);
        r.out_x = c.pos_x;
        r.out_y = c.pos_y;
        r.out_z = c.pos_z;
        results_due.insert(results_due.size(), r);
      end
      default: ;
    endcase
  endfunction

  // command driver: hold a stalled transfer, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || !cmd_stall) begin
      if (cmd_valid) predict_command(cmd);
      if (cmd_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
        cmd <= cmd_backlog.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_arm && hold_count < HOLD_CYCLES) begin
      res_stall <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      res_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  function automatic void report_field(string name, logic signed [31:0] want,
                                       logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    psm_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got class %0d at (%0d, %0d, %0d)",
                 $time, res.point_class, res.out_x, res.out_y, res.out_z);
        errors++;
      end else begin
        want = results_due.pop_front();
        report_field("point_class", 32'(want.point_class), 32'(res.point_class));
        report_field("keep_point", 32'(want.keep_point), 32'(res.keep_point));
        report_field("out_x", 32'(want.out_x), 32'(res.out_x));
        report_field("out_y", 32'(want.out_y), 32'(res.out_y));
        report_field("out_z", 32'(want.out_z), 32'(res.out_z));
      end
    end
  end

  task automatic push_cmd(logic [1:0] op, int x, int y, int z);
    psm_pkg::cmd_t c;
    c.opcode = op;
    c.pos_x = x[15:0];
    c.pos_y = y[15:0];
    c.pos_z = z[15:0];
    cmd_backlog.insert(cmd_backlog.size(), c);
  endtask

  function automatic psm_pkg::point_t any_point();
    psm_pkg::point_t p;
    p.x = 16'($urandom);
    p.y = 16'($urandom);
    p.z = 16'($urandom);
    return p;
  endfunction

  function automatic logic signed [15:0] clip(int v);
    if (v > COORD_MAX) return 16'(COORD_MAX);
    if (v < -COORD_MAX - 1) return 16'(-COORD_MAX - 1);
    return v[15:0];
  endfunction

  function automatic psm_pkg::point_t nudge(psm_pkg::point_t p, int span);
    psm_pkg::point_t q;
    q.x = clip(int'(p.x) + int'($urandom_range(0, 2 * span)) - span);
    q.y = clip(int'(p.y) + int'($urandom_range(0, 2 * span)) - span);
    q.z = clip(int'(p.z) + int'($urandom_range(0, 2 * span)) - span);
    return q;
  endfunction

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || cmd_valid || results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_radius(logic [0:0] idx, logic [psm_pkg::RADIUS_W-1:0] value);
    logic [psm_pkg::APB_DATA_W-1:0] readback;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback[psm_pkg::RADIUS_W-1:0] !== value) begin
      $display("%0t: register %0d readback mismatch, expected %0d, got %0d",
               $time, idx, value, readback[psm_pkg::RADIUS_W-1:0]);
      errors++;
    end
    if (idx == psm_pkg::REG_ROBOT_RADIUS) robot_r = value;
    else interest_r = value;
  endtask

  task automatic run_phase(logic [psm_pkg::RADIUS_W-1:0] robot,
                           logic [psm_pkg::RADIUS_W-1:0] interest, int budget);
    psm_pkg::point_t placed[$];
    psm_pkg::point_t centre;
    psm_pkg::point_t p;
    logic [1:0] op;
    int made;
    int span;
    int n;
    int idx;
    set_radius(psm_pkg::REG_ROBOT_RADIUS, robot);
    set_radius(psm_pkg::REG_INTEREST_RADIUS, interest);
    span = ((robot > interest) ? int'(robot) : int'(interest)) + 20;
    made = 0;
    while (made < budget) begin
      if ($urandom_range(0, 99) < 15 || placed.size() == 0 && $urandom_range(0, 9) == 0) begin
        op = 2'($urandom);
        p = any_point();
        push_cmd(op, int'(p.x), int'(p.y), int'(p.z));
        if (op != OP_UNUSED) made++;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          p = any_point();
          push_cmd(psm_pkg::OP_CLEAR, int'(p.x), int'(p.y), int'(p.z));
          placed.delete();
          made++;
        end
        centre = any_point();
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(55, 72) : $urandom_range(1, 8);
        repeat (n) begin
          p = nudge(centre, 2 * span);
          push_cmd(psm_pkg::OP_APPEND, int'(p.x), int'(p.y), int'(p.z));
          placed.insert(placed.size(), p);
          made++;
        end
        repeat ($urandom_range(1, 6)) begin
          idx = $urandom_range(0, placed.size() - 1);
          case ($urandom_range(0, 3))
            0: p = any_point();
            1: p = placed[idx];
            default: p = nudge(placed[idx], span);
          endcase
          push_cmd(psm_pkg::OP_CLASSIFY, int'(p.x), int'(p.y), int'(p.z));
          made++;
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_cmd(psm_pkg::OP_CLASSIFY, 0, 0, 0);
    push_cmd(psm_pkg::OP_CLASSIFY, 32767, -32768, 32767);
    push_cmd(OP_UNUSED, -1, -1, -1);
    push_cmd(psm_pkg::OP_APPEND, 0, 0, 0);
    push_cmd(psm_pkg::OP_CLASSIFY, 50, 0, 0);
    push_cmd(psm_pkg::OP_CLASSIFY, 300, 0, 0);
    push_cmd(psm_pkg::OP_CLASSIFY, 0, 500, 0);
    push_cmd(psm_pkg::OP_CLASSIFY, 0, 0, 100);
    push_cmd(psm_pkg::OP_CLASSIFY, 0, -99, 0);
    push_cmd(psm_pkg::OP_APPEND, 32767, 32767, 32767);
    push_cmd(psm_pkg::OP_APPEND, -32768, -32768, -32768);
    push_cmd(psm_pkg::OP_CLASSIFY, -32768, -32768, -32768);
    push_cmd(psm_pkg::OP_CLASSIFY, 32767, 32767, -32768);
    push_cmd(OP_UNUSED, 0, 0, 0);
    push_cmd(psm_pkg::OP_CLASSIFY, 32600, 32767, 32767);
    push_cmd(psm_pkg::OP_CLEAR, 0, 0, 0);
    push_cmd(psm_pkg::OP_CLASSIFY, 0, 0, 0);
    push_cmd(psm_pkg::OP_APPEND, 1000, 1000, 1000);
    push_cmd(psm_pkg::OP_CLASSIFY, 1000, 1000, 1000);
    wait_drained();

    hold_arm <= 1'b1;
    run_phase(16'd100, 16'd500, 130);
    run_phase(16'd0, 16'd0, 110);
    quiet <= 1'b1;
    run_phase(16'd65535, 16'd65535, 110);
    quiet <= 1'b0;
    run_phase(16'd0, 16'd65535, 110);
    run_phase(16'd300, 16'd200, 110);
    run_phase(16'd65535, 16'd0, 100);
    run_phase(16'd1500, 16'd6000, 110);
    run_phase(16'd40, 16'd200, 130);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/psm_pkg.sv
rtl/psm_cell.sv
rtl/psm_dist.sv
rtl/point_sphere_model_classifier_core.sv
tb/sv/testbench.sv
